/* rtl/stribeck_friction_feedforward_defines.svh */
// ----------------------------------------------------------------------------
// Stribeck friction feedforward: assertion macros
// Shared property shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STRIBECK_FRICTION_FEEDFORWARD_DEFINES_SVH
`define STRIBECK_FRICTION_FEEDFORWARD_DEFINES_SVH

// Same-cycle implication.
`define SFF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sff_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_pkg
// Constants, codes and bundle types shared by the friction feedforward block.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int SFF_JOINTS_DEF    = 32;
  localparam int SFF_EXP_DEPTH_DEF = 256;

  localparam int COEFS    = 5;
  localparam int EXP_SPAN = 16;

  // 0.229 rpm -> rad/s in Q16.16, and the 0.03 rad/s deadband
  localparam int                 VEL_SCALE_Q16 = 1572;
  localparam logic signed [31:0] DEADBAND_Q16  = 32'sd1966;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PROC = 1'b1;

  localparam logic [2:0] SEL_INERTIA = 3'd0;
  localparam logic [2:0] SEL_VISCOUS = 3'd1;
  localparam logic [2:0] SEL_STATIC  = 3'd2;
  localparam logic [2:0] SEL_COULOMB = 3'd3;
  localparam logic [2:0] SEL_INV_VS  = 3'd4;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;
  localparam int LIMIT_W    = 15;
  localparam int MPT_W      = 31;
  localparam int RATE_W     = 10;

  localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_LIMIT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MA_PER_TORQUE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_RATE     = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd0;
  localparam logic [MPT_W-1:0]   MPT_RST   = 31'd65536000;
  localparam logic [RATE_W-1:0]  RATE_RST  = 10'd100;

  typedef struct packed {
    logic               we;
    logic signed [31:0] data;
  } sff_coef_wr_t;

  typedef struct packed {
    logic               we;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } sff_st_wr_t;

  typedef struct packed {
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } sff_st_rd_t;

endpackage

/* rtl/sff_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_mul
// Shared signed 34x34 multiplier with a registered product.
// ----------------------------------------------------------------------------
module sff_mul
  import sff_pkg::*;
(
  input  logic               clk,
  input  logic signed [33:0] op_a,
  input  logic signed [33:0] op_b,
  output logic signed [67:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

/* rtl/sff_exp_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_exp_rom
// exp(-16*i/depth) table in unsigned Q1.16, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module sff_exp_rom
  import sff_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = SFF_EXP_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] rd_idx,
  output logic [16:0]                        exp_q_r
);

  typedef logic [16:0] rom_t [EXP_TABLE_DEPTH];

  localparam logic [63:0] ONE_Q31 = 64'h8000_0000;

  // exp(-f), f in [0,1] as Q1.31, 15-term Taylor series
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] p;
    term = ONE_Q31;
    sum  = ONE_Q31;
    for (int k = 1; k <= 14; k++) begin
      p = (term * f) >> 31;
      case (k)
        1:       term = p;
        2:       term = p / 64'd2;
        3:       term = p / 64'd3;
        4:       term = p / 64'd4;
        5:       term = p / 64'd5;
        6:       term = p / 64'd6;
        7:       term = p / 64'd7;
        8:       term = p / 64'd8;
        9:       term = p / 64'd9;
        10:      term = p / 64'd10;
        11:      term = p / 64'd11;
        12:      term = p / 64'd12;
        13:      term = p / 64'd13;
        14:      term = p / 64'd14;
        default: term = p;
      endcase
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] e1;
    logic [63:0] y;
    logic [63:0] n;
    logic [63:0] val;
    e1 = exp_neg_q31(ONE_Q31);
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      y   = ((64'(i) * 64'(EXP_SPAN)) << 31) / 64'(EXP_TABLE_DEPTH);
      n   = y >> 31;
      val = exp_neg_q31(y & (ONE_Q31 - 64'd1));
      for (int j = 0; j < EXP_SPAN; j++) begin
        if (64'(j) < n) begin
          val = (val * e1) >> 31;
        end
      end
      rom[i] = 17'((val + 64'd16384) >> 15);
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  always_ff @(posedge clk) begin
    exp_q_r <= EXP_ROM[rd_idx];
  end

endmodule

/* rtl/sff_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_store
// Coefficient memory (five words per joint) and per-joint velocity/accel
// memory with valid bits; unwritten state entries read as zero.
// ----------------------------------------------------------------------------
module sff_store
  import sff_pkg::*;
#(
  parameter int JOINTS = SFF_JOINTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [$clog2(JOINTS*COEFS)-1:0]         coef_waddr,
  input  sff_coef_wr_t                            coef_wr,
  input  logic [$clog2(JOINTS*COEFS)-1:0]         coef_raddr,
  output logic signed [31:0]                      coef_q_r,
  input  logic [((JOINTS > 1) ? $clog2(JOINTS) : 1)-1:0] st_raddr,
  input  logic [((JOINTS > 1) ? $clog2(JOINTS) : 1)-1:0] st_waddr,
  input  sff_st_wr_t                              st_wr,
  output sff_st_rd_t                              st_q
);

  localparam int CDEPTH = JOINTS * COEFS;

  logic signed [31:0] coef_mem [CDEPTH];
  logic [63:0]        st_mem [JOINTS];
  logic [JOINTS-1:0]  st_valid_r;
  logic [63:0]        st_word_r;
  logic               rd_valid_r;

  always_ff @(posedge clk) begin
    if (coef_wr.we) begin
      coef_mem[coef_waddr] <= coef_wr.data;
    end
    coef_q_r <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_wr.we) begin
      st_mem[st_waddr] <= {st_wr.vel, st_wr.acc};
    end
    st_word_r <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (st_wr.we) begin
        st_valid_r[st_waddr] <= 1'b1;
      end
      rd_valid_r <= st_valid_r[st_raddr];
    end
  end

  assign st_q = rd_valid_r ? sff_st_rd_t'(st_word_r) : '0;

endmodule

/* rtl/stribeck_friction_feedforward.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stribeck_friction_feedforward
// Per-joint inertia + Stribeck friction feedforward, Q16.16, one shared
// multiplier stepped by a one-hot sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall) carry either a coefficient load
//   (action 0) or a joint sample (action 1). Result beats (out_valid/
//   out_stall) carry one goal current per processed sample.
//   A load beat is absorbed in its accept cycle; the block takes the next
//   beat in the following cycle. Loads and samples for joints at or above
//   JOINTS are dropped without a result.
//   A sample beat runs 12 sequencer steps, ten of them on the one 34x34
//   multiplier (velocity scale, differentiation, Stribeck ratio, square,
//   ROM index, inertia, friction, viscous, two mA partial products). The
//   result is registered after the final step, and in_stall stays high
//   until the sequencer is back in idle, so no new sample is taken before
//   the last is through. The multiplier, used once per step, sets the pace.
//   The result register is separate from the sequencer: a new beat is
//   accepted while an earlier result waits. If the receiver stalls and the
//   next result is ready, the sequencer holds on its final step.
//   Reset (synchronous, rst_n low) returns to idle, restores the register
//   defaults and clears the velocity/accel valid bits; the coefficient
//   memory is not cleared and must be loaded before a joint is processed.
//   The user writes configuration via cfg_we/cfg_addr/cfg_wdata while idle; not enforced.
// ----------------------------------------------------------------------------
`include "stribeck_friction_feedforward_defines.svh"

module stribeck_friction_feedforward
  import sff_pkg::*;
#(
  parameter int JOINTS          = SFF_JOINTS_DEF,
  parameter int EXP_TABLE_DEPTH = SFF_EXP_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  // input beats
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_action,
  input  logic [4:0]              in_joint,
  input  logic [2:0]              in_coef_sel,
  input  logic signed [31:0]      in_coef_value,
  input  logic signed [15:0]      in_vel_raw,
  input  logic                    in_read_ok,
  // result beats
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [4:0]              out_joint,
  output logic signed [15:0]      out_goal_current_ma
);

  localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int CAW = $clog2(JOINTS * COEFS);
  localparam int IW  = $clog2(EXP_TABLE_DEPTH);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_VEL  = 13'b0000000000010,  // vel_raw * scale
    ST_ACC  = 13'b0000000000100,  // (v_new - v_old) * rate
    ST_SAT  = 13'b0000000001000,  // clamp accel, |v| * |inv_vs|
    ST_RAT  = 13'b0000000010000,  // ratio^2
    ST_SQ   = 13'b0000000100000,  // x * depth
    ST_IDX  = 13'b0000001000000,  // ROM read, inertia * accel
    ST_ROM  = 13'b0000010000000,  // (Ts - Tc) * exp
    ST_EXT  = 13'b0000100000000,  // add friction, viscous * v
    ST_VIS  = 13'b0001000000000,  // add viscous
    ST_ABS  = 13'b0010000000000,  // lo * mA scale
    ST_HI   = 13'b0100000000000,  // hi * mA scale
    ST_OUT  = 13'b1000000000000   // clamp, sign, hand to output reg
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [LIMIT_W-1:0] limit_r;
  logic [MPT_W-1:0]   mpt_r;
  logic [RATE_W-1:0]  rate_r;

  // latched sample
  logic [4:0]         joint_r;
  logic signed [15:0] vel_raw_r;
  logic               ok_r;

  // working registers
  logic signed [31:0] v_r, a_r;
  logic signed [31:0] inertia_r, viscous_r, static_r, coulomb_r, inv_vs_r;
  logic signed [32:0] cdiff_r;
  logic               big_r;
  logic signed [51:0] acc_r;
  logic [19:0]        hi_r;
  logic               neg_r;
  logic [30:0]        t_r;

  // output register
  logic               out_valid_r;
  logic [4:0]         out_joint_r;
  logic signed [15:0] out_goal_r;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  // stores
  sff_coef_wr_t       coef_wr;
  logic [CAW-1:0]     coef_waddr, coef_raddr;
  logic signed [31:0] coef_q;
  logic [2:0]         rd_sel;
  logic [4:0]         rd_joint;
  sff_st_wr_t         st_wr;
  sff_st_rd_t         st_q;
  logic [JW-1:0]      st_raddr;

  // ROM
  logic [IW-1:0]      rom_idx;
  logic [16:0]        rom_q;
  logic [16:0]        exp_val;

  // datapath nets
  logic               in_take, in_hit, out_load;
  logic signed [31:0] vn;
  logic signed [32:0] vdiff;
  logic signed [31:0] acc_sat;
  logic signed [51:0] prod_sh, ext;
  logic signed [51:0] mag;
  logic               sgn_pos, sgn_neg;
  logic [51:0]        out_sum;
  logic [LIMIT_W-1:0] out_mag;
  logic signed [16:0] goal17, lim17;

  function automatic logic [CAW-1:0] caddr(input logic [4:0] j, input logic [2:0] s);
    return CAW'(j) * CAW'(COEFS) + CAW'(s);
  endfunction

  function automatic logic signed [33:0] abs34(input logic signed [31:0] x);
    logic signed [33:0] w;
    w = 34'(x);
    return x[31] ? -w : w;
  endfunction

  assign in_take  = in_valid && !in_stall;
  assign in_hit   = 9'(in_joint) < 9'(JOINTS);
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      mpt_r   <= MPT_RST;
      rate_r  <= RATE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CURRENT_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_MA_PER_TORQUE: mpt_r   <= cfg_wdata[MPT_W-1:0];
        REG_LOOP_RATE:     rate_r  <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stores
  always_comb begin
    rd_joint = joint_r;
    case (state_r)
      ST_IDLE: begin
        rd_joint = in_joint;
        rd_sel   = SEL_INV_VS;
      end
      ST_VEL:  rd_sel = SEL_INERTIA;
      ST_ACC:  rd_sel = SEL_VISCOUS;
      ST_SAT:  rd_sel = SEL_STATIC;
      ST_RAT:  rd_sel = SEL_COULOMB;
      default: rd_sel = SEL_INERTIA;
    endcase
  end

  assign coef_raddr   = caddr(rd_joint, rd_sel);
  assign coef_waddr   = caddr(in_joint, in_coef_sel);
  assign coef_wr.we   = in_take && in_hit && (in_action == ACT_LOAD) &&
                        (in_coef_sel < 3'(COEFS));
  assign coef_wr.data = in_coef_value;
  assign st_raddr     = JW'(rd_joint);

  // new state lands at the end of the clamp step
  assign st_wr.we  = (state_r == ST_SAT) && ok_r;
  assign st_wr.vel = v_r;
  assign st_wr.acc = acc_sat;

  sff_store #(
    .JOINTS(JOINTS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef_waddr (coef_waddr),
    .coef_wr    (coef_wr),
    .coef_raddr (coef_raddr),
    .coef_q_r   (coef_q),
    .st_raddr   (st_raddr),
    .st_waddr   (JW'(joint_r)),
    .st_wr      (st_wr),
    .st_q       (st_q)
  );

  // ----------------------------------------------------------- datapath nets
  assign vn      = mul_p[31:0];
  assign vdiff   = 33'(vn) - 33'(st_q.vel);
  assign prod_sh = mul_p[67:16];           // Q16.16 product, floored
  assign ext     = prod_sh + 52'(coulomb_r);
  assign mag     = acc_r[51] ? -acc_r : acc_r;
  assign sgn_pos = v_r > DEADBAND_Q16;
  assign sgn_neg = v_r < -DEADBAND_Q16;
  assign exp_val = big_r ? 17'd0 : rom_q;
  assign out_sum = mul_p[51:0] + 52'(t_r);
  assign out_mag = (out_sum > 52'(limit_r)) ? limit_r : out_sum[LIMIT_W-1:0];

  // accel clamp to int32
  always_comb begin
    if (!mul_p[67] && (|mul_p[66:31])) begin
      acc_sat = 32'sh7fff_ffff;
    end else if (mul_p[67] && !(&mul_p[66:31])) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = mul_p[31:0];
    end
  end

  // x = ratio^2 >> 16 sits in the product; index = x * depth >> 20
  assign rom_idx = mul_p[20 +: IW];

  sff_exp_rom #(
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) u_exp_rom (
    .clk     (clk),
    .rd_idx  (rom_idx),
    .exp_q_r (rom_q)
  );

  // ------------------------------------------------------ multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_VEL: begin
        mul_a = 34'(vel_raw_r);
        mul_b = 34'(VEL_SCALE_Q16);
      end
      ST_ACC: begin
        mul_a = 34'(vdiff);
        mul_b = {24'd0, rate_r};
      end
      ST_SAT: begin
        mul_a = abs34(v_r);
        mul_b = abs34(inv_vs_r);
      end
      ST_RAT: begin
        mul_a = {16'd0, mul_p[33:16]};
        mul_b = {16'd0, mul_p[33:16]};
      end
      ST_SQ: begin
        mul_a = {14'd0, mul_p[35:16]};
        mul_b = 34'(EXP_TABLE_DEPTH);
      end
      ST_IDX: begin
        mul_a = 34'(inertia_r);
        mul_b = 34'(a_r);
      end
      ST_ROM: begin
        mul_a = 34'(cdiff_r);
        mul_b = {17'd0, exp_val};
      end
      ST_EXT: begin
        mul_a = 34'(viscous_r);
        mul_b = 34'(v_r);
      end
      ST_ABS: begin
        mul_a = {2'b00, mag[31:0]};
        mul_b = {3'b000, mpt_r};
      end
      // operands stay put on the final step so a stalled result keeps hi * scale
      ST_HI, ST_OUT: begin
        mul_a = {14'd0, hi_r};
        mul_b = {3'b000, mpt_r};
      end
      default: ;
    endcase
  end

  sff_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take && in_hit && (in_action == ACT_PROC)) begin
          state_nxt = ST_VEL;
        end
      end
      ST_VEL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_RAT;
      ST_RAT:  state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_IDX;
      ST_IDX:  state_nxt = ST_ROM;
      ST_ROM:  state_nxt = ST_EXT;
      ST_EXT:  state_nxt = ST_VIS;
      ST_VIS:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_HI;
      ST_HI:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // step registers; coefficient reads arrive in the step after issue
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          joint_r   <= in_joint;
          vel_raw_r <= in_vel_raw;
          ok_r      <= in_read_ok;
        end
      end
      ST_VEL: inv_vs_r <= coef_q;
      ST_ACC: begin
        inertia_r <= coef_q;
        v_r       <= ok_r ? vn : st_q.vel;
      end
      ST_SAT: begin
        viscous_r <= coef_q;
        a_r       <= ok_r ? acc_sat : st_q.acc;
      end
      ST_RAT: begin
        static_r <= coef_q;
        big_r    <= |mul_p[67:34];        // ratio >= 4.0
      end
      ST_SQ:  coulomb_r <= coef_q;
      ST_IDX: cdiff_r   <= 33'(static_r) - 33'(coulomb_r);
      ST_ROM: acc_r     <= prod_sh;
      ST_EXT: begin
        if (sgn_pos) begin
          acc_r <= acc_r + ext;
        end else if (sgn_neg) begin
          acc_r <= acc_r - ext;
        end
      end
      ST_VIS: acc_r <= acc_r + prod_sh;
      ST_ABS: begin
        hi_r  <= mag[51:32];
        neg_r <= acc_r[51];
      end
      ST_HI:  t_r <= mul_p[62:32];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_joint_r <= joint_r;
      out_goal_r  <= neg_r ? -{1'b0, out_mag} : {1'b0, out_mag};
    end
  end

  assign out_valid           = out_valid_r;
  assign out_joint           = out_joint_r;
  assign out_goal_current_ma = out_goal_r;

  // -------------------------------------------------------------- assertions
  assign goal17 = 17'(out_goal_current_ma);
  assign lim17  = $signed({2'b00, limit_r});

  `SFF_ASSERT_IMP(a_goal_in_limit, out_valid, (goal17 <= lim17) && (goal17 >= -lim17), "goal current beyond limit")
  `SFF_ASSERT_NXT(a_load_no_busy, in_take && ((in_action == ACT_LOAD) || !in_hit), !in_stall, "load or dropped beat made block busy")
  `SFF_ASSERT_NXT(a_proc_starts, in_take && in_hit && (in_action == ACT_PROC), state_r == ST_VEL, "sample did not start sequence")
  `SFF_ASSERT_NXT(a_hold_result, (state_r == ST_OUT) && out_valid && out_stall, state_r == ST_OUT, "result dropped under stall")

endmodule

/* dv/stribeck_friction_feedforward_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stribeck_friction_feedforward_test
// Self-checking bench for the friction feedforward block. A scoreboard class
// predicts every goal current from the accepted beats; driver tasks load
// coefficients and stream joint samples under random idling and back-pressure.
// ----------------------------------------------------------------------------
module stribeck_friction_feedforward_test;
  import sff_pkg::*;

  localparam int     CLK_HALF     = 2;
  localparam int     RESET_CYCLES = 12;
  localparam int     MAX_WAIT     = 18;
  // drain margin once every result is back
  localparam int     DRAIN_CYCLES = 32;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     PHASE_BEATS  = 310;
  localparam int     NUM_PHASES   = 6;
  localparam longint TIMEOUT_NS   = 2_500_000;
  localparam int     NJ           = SFF_JOINTS_DEF;
  localparam int     LUT_DEPTH    = SFF_EXP_DEPTH_DEF;
  localparam longint ACC_MAX      = 64'sd2147483647;
  localparam longint ACC_MIN      = -64'sd2147483648;

  typedef struct {
    logic               action;
    logic [4:0]         joint;
    logic [2:0]         sel;
    logic signed [31:0] value;
    logic signed [15:0] vel;
    logic               read_ok;
  } joint_beat_t;

  typedef struct {
    logic [4:0]         joint;
    logic signed [15:0] current;
  } current_cmd_t;

  // --------------------------------------------------------------------------
  // Goal-current scoreboard: own copy of the coefficient, velocity and accel
  // stores plus the three registers; queues one command per joint sample.
  // --------------------------------------------------------------------------
  class current_scoreboard;
    int                  coef[NJ*COEFS];
    int                  vel_q16[NJ];
    int                  acc_q16[NJ];
    logic [LIMIT_W-1:0]  limit_ma;
    logic [MPT_W-1:0]    ma_per_nm;
    logic [RATE_W-1:0]   rate_hz;
    longint unsigned     exp_lut[LUT_DEPTH];
    current_cmd_t        pending_currents[$];
    int                  mismatches;
    int                  checked;

    function new();
      longint unsigned one_q31, e1, y, n, val;
      one_q31 = 64'd1 << 31;
      limit_ma  = LIMIT_RST;
      ma_per_nm = MPT_RST;
      rate_hz   = RATE_RST;
      foreach (coef[i]) coef[i] = 0;
      foreach (vel_q16[i]) begin
        vel_q16[i] = 0;
        acc_q16[i] = 0;
      end
      mismatches = 0;
      checked    = 0;
      // exp(-16*i/depth): fractional part by series, integer part by e^-1 steps
      e1 = exp_neg_q31(one_q31);
      for (int i = 0; i < LUT_DEPTH; i++) begin
        y   = ((longint'(i) * EXP_SPAN) << 31) / LUT_DEPTH;
        n   = y >> 31;
        val = exp_neg_q31(y & (one_q31 - 1));
        while (n > 0) begin
          val = (val * e1) >> 31;
          n--;
        end
        exp_lut[i] = (val + (64'd1 << 14)) >> 15;
      end
    endfunction

    // Q1.31 in and out, 15-term Taylor series
    function longint unsigned exp_neg_q31(longint unsigned f);
      longint unsigned term, sum;
      term = 64'd1 << 31;
      sum  = term;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * f) >> 31) / longint'(k);
        if (k % 2 == 1) sum -= term;
        else sum += term;
      end
      return sum;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CURRENT_LIMIT: limit_ma  = data[LIMIT_W-1:0];
        REG_MA_PER_TORQUE: ma_per_nm = data[MPT_W-1:0];
        REG_LOOP_RATE:     rate_hz   = data[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint stribeck_lut(longint v, longint inv_vs);
      longint unsigned av, ai, ratio, x, idx;
      av    = (v < 0) ? -v : v;
      ai    = (inv_vs < 0) ? -inv_vs : inv_vs;
      ratio = (av * ai) >> 16;
      if (ratio >= (64'd4 << 16)) return 0;
      x   = (ratio * ratio) >> 16;
      idx = (x * LUT_DEPTH) / (64'(EXP_SPAN) << 16);
      if (idx >= LUT_DEPTH) return 0;
      return longint'(exp_lut[idx]);
    endfunction

    function void note_beat(joint_beat_t b);
      int              base;
      longint          vn, acc, v, a, sgn, tau, fexp;
      longint unsigned mag, m;
      logic [15:0]     cmd;
      current_cmd_t    r;
      if (b.action == ACT_LOAD) begin
        if (b.sel < COEFS) coef[b.joint * COEFS + b.sel] = b.value;
        return;
      end
      if (b.read_ok) begin
        vn  = longint'(b.vel) * VEL_SCALE_Q16;
        acc = (vn - longint'(vel_q16[b.joint])) * longint'(rate_hz);
        if (acc > ACC_MAX) acc = ACC_MAX;
        if (acc < ACC_MIN) acc = ACC_MIN;
        vel_q16[b.joint] = int'(vn);
        acc_q16[b.joint] = int'(acc);
      end
      base = b.joint * COEFS;
      v    = vel_q16[b.joint];
      a    = acc_q16[b.joint];
      sgn  = 0;
      if (v > DEADBAND_Q16) sgn = 1;
      else if (v < -DEADBAND_Q16) sgn = -1;
      fexp = stribeck_lut(v, coef[base + SEL_INV_VS]);
      tau = ((longint'(coef[base + SEL_INERTIA]) * a) >>> 16)
          + sgn * longint'(coef[base + SEL_COULOMB])
          + sgn * (((longint'(coef[base + SEL_STATIC])
                     - longint'(coef[base + SEL_COULOMB])) * fexp) >>> 16)
          + ((longint'(coef[base + SEL_VISCOUS]) * v) >>> 16);
      mag = (tau < 0) ? -tau : tau;
      m   = ma_per_nm;
      mag = (mag >> 32) * m + (((mag & 64'hFFFF_FFFF) * m) >> 32);
      if (mag > limit_ma) mag = limit_ma;
      cmd = mag[15:0];
      if (tau < 0) cmd = -cmd;
      r.joint   = b.joint;
      r.current = cmd;
      pending_currents.insert(pending_currents.size(), r);
    endfunction

    function void check_current(logic [4:0] j, logic signed [15:0] cur);
      current_cmd_t e;
      checked++;
      if (pending_currents.size() == 0) begin
        $error("result beat with nothing expected: joint %0d current %0d", j, cur);
        mismatches++;
        return;
      end
      e = pending_currents.pop_front();
      if (e.joint !== j) begin
        $error("out_joint: expected %0d, got %0d", e.joint, j);
        mismatches++;
      end
      if (e.current !== cur) begin
        $error("out_goal_current_ma: expected %0d, got %0d", e.current, cur);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_action;
  logic [4:0]            in_joint;
  logic [2:0]            in_coef_sel;
  logic signed [31:0]    in_coef_value;
  logic signed [15:0]    in_vel_raw;
  logic                  in_read_ok;
  logic                  out_valid;
  logic                  out_stall;
  logic [4:0]            out_joint;
  logic signed [15:0]    out_goal_current_ma;

  current_scoreboard sb = new();

  // Which coefficients each joint has had loaded; a joint is only sampled
  // once all five are in, since the coefficient store powers up undefined.
  bit [COEFS-1:0] loaded[NJ];

  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  bit hold_req   = 1'b0;
  int holds_done = 0;
  int n_loads    = 0;
  int n_stray    = 0;
  int n_samples  = 0;
  int n_bad_read = 0;

  stribeck_friction_feedforward #(
    .JOINTS          (NJ),
    .EXP_TABLE_DEPTH (LUT_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_joint            (in_joint),
    .in_coef_sel         (in_coef_sel),
    .in_coef_value       (in_coef_value),
    .in_vel_raw          (in_vel_raw),
    .in_read_ok          (in_read_ok),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_joint           (out_joint),
    .out_goal_current_ma (out_goal_current_ma)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hard stop in case a beat never comes back.
  initial begin
    #(TIMEOUT_NS);
    $display("stribeck_friction_feedforward_test: FAIL");
    $finish;
  end

  // Idle draw shared by both sides: at least a quarter of the time no wait at all.
  function automatic int pick_wait();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Mostly plausible friction figures, with some raw words and extremes.
  function automatic logic signed [31:0] pick_coef(logic [2:0] sel);
    int                 mode;
    logic signed [31:0] c;
    mode = $urandom_range(0, 9);
    if (mode == 0) return $urandom;
    if (mode == 1) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    case (sel)
      SEL_INERTIA: c = $urandom_range(0, 65536);
      SEL_VISCOUS: c = $urandom_range(0, 20000);
      SEL_STATIC:  c = $urandom_range(0, 131072);
      SEL_COULOMB: c = $urandom_range(0, 98304);
      default:     c = $urandom_range(65536, 50 * 65536);
    endcase
    if ($urandom_range(0, 7) == 0) c = -c;
    return c;
  endfunction

  // Small speeds reach the Stribeck dip and the deadband; the rest spans
  // the full range so accel saturation and a zero exp term show up.
  function automatic logic signed [15:0] pick_vel();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = 16'sd0;
          3:       v = 16'sd1;
          default: v = 16'sd2;
        endcase
      end
      2, 3:    v = 16'($urandom_range(0, 2000));
      default: v = 16'($urandom_range(0, 64));
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic joint_beat_t mk_beat(logic act, logic [4:0] j, logic [2:0] sel,
                                          logic signed [31:0] val, logic signed [15:0] vel,
                                          logic ok);
    joint_beat_t b;
    b.action  = act;
    b.joint   = j;
    b.sel     = sel;
    b.value   = val;
    b.vel     = vel;
    b.read_ok = ok;
    return b;
  endfunction

  // Well-formed traffic: a joint without a full coefficient set gets its
  // next missing load instead of a sample. A tenth of the beats reload a
  // coefficient at random, now and then with an out-of-range selector.
  function automatic void make_random_beat(output joint_beat_t b);
    int j;
    b.vel     = 16'($urandom);
    b.read_ok = 1'($urandom);
    b.sel     = 3'($urandom);
    b.value   = $urandom;
    j         = $urandom_range(0, NJ - 1);
    b.joint   = 5'(j);
    if ($urandom_range(0, 99) < 10) begin
      b.action = ACT_LOAD;
      if ($urandom_range(0, 19) == 0) b.sel = 3'($urandom_range(COEFS, 7));
      else b.sel = 3'($urandom_range(0, COEFS - 1));
      b.value = pick_coef(b.sel);
    end else if (!(&loaded[j])) begin
      b.action = ACT_LOAD;
      for (int s = COEFS - 1; s >= 0; s--)
        if (!loaded[j][s]) b.sel = 3'(s);
      b.value = pick_coef(b.sel);
    end else begin
      b.action  = ACT_PROC;
      b.vel     = pick_vel();
      b.read_ok = ($urandom_range(0, 4) != 0);
    end
  endfunction

  // One input beat: optional idle gap, then hold the beat until accepted.
  // With no gap, valid simply stays high and only the payload moves on.
  task automatic send_beat(joint_beat_t b);
    int gap;
    gap = send_quiet ? 0 : pick_wait();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_action     = b.action;
    in_joint      = b.joint;
    in_coef_sel   = b.sel;
    in_coef_value = b.value;
    in_vel_raw    = b.vel;
    in_read_ok    = b.read_ok;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
    if (b.action == ACT_LOAD) begin
      n_loads++;
      if (b.sel < COEFS) loaded[b.joint][b.sel] = 1'b1;
      else n_stray++;
    end else begin
      n_samples++;
      if (!b.read_ok) n_bad_read++;
    end
  endtask

  // Stop offering, wait for every queued command, then let the sequencer
  // run dry so a register write cannot land mid-computation.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_currents.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [LIMIT_W-1:0] lim, logic [MPT_W-1:0] mpt,
                            logic [RATE_W-1:0] rate);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = REG_CURRENT_LIMIT;
    cfg_wdata = CFG_DATA_W'(lim);
    sb.set_reg(cfg_addr, cfg_wdata);
    @(negedge clk);
    cfg_addr  = REG_MA_PER_TORQUE;
    cfg_wdata = CFG_DATA_W'(mpt);
    sb.set_reg(cfg_addr, cfg_wdata);
    @(negedge clk);
    cfg_addr  = REG_LOOP_RATE;
    cfg_wdata = CFG_DATA_W'(rate);
    sb.set_reg(cfg_addr, cfg_wdata);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Result side: a fresh stall draw per beat. A pending hold request turns
  // into one long stall so the result register and sequencer both fill and
  // the block has to push back on its input.
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        n        = HOLD_CYCLES;
        hold_req = 1'b0;
        holds_done++;
      end else begin
        n = recv_quiet ? 0 : pick_wait();
      end
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_current(out_joint, out_goal_current_ma);
  end

  // Register settings per random phase. Phase 1 clamps everything to zero,
  // phase 2 zeroes accel via a zero loop rate, phase 3 runs the widest
  // scale and rate under the long hold-off, phase 4 is redrawn at random.
  int unsigned ph_limit[NUM_PHASES] = '{32767, 0, 32767, 32767, 1, 20000};
  int unsigned ph_mpt[NUM_PHASES]   = '{65536000, 2147483647, 131072000, 2147483647, 1, 0};
  int unsigned ph_rate[NUM_PHASES]  = '{100, 1, 0, 1023, 1, 1000};

  initial begin : stimulus
    joint_beat_t b;
    int          done;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_CURRENT_LIMIT;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_action     = ACT_LOAD;
    in_joint      = '0;
    in_coef_sel   = SEL_INERTIA;
    in_coef_value = '0;
    in_vel_raw    = '0;
    in_read_ok    = 1'b0;
    foreach (loaded[i]) loaded[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: full-scale limit, fast loop so accel saturates on big steps.
    write_regs(15'd32767, 31'd65536000, 10'd1000);
    // joint 0: modest coefficients, inv_vs = 10 (Stribeck dip below 0.4 rad/s)
    send_beat(mk_beat(ACT_LOAD, 5'd0, SEL_INERTIA, 32'sh0000_8000, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd0, SEL_VISCOUS, 32'sh0000_1999, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd0, SEL_STATIC, 32'sh0001_0000, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd0, SEL_COULOMB, 32'sh0000_8000, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd0, SEL_INV_VS, 32'sh000A_0000, 16'sd0, 1'b0));
    // selectors past the last coefficient must be dropped
    send_beat(mk_beat(ACT_LOAD, 5'd0, 3'(COEFS), 32'sh7FFF_FFFF, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd0, 3'(COEFS + 2), -32'sd1, 16'sd0, 1'b0));
    // joint 31: extreme coefficients and a negative inv_vs
    send_beat(mk_beat(ACT_LOAD, 5'd31, SEL_INERTIA, 32'sh7FFF_FFFF, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd31, SEL_VISCOUS, 32'sh8000_0000, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd31, SEL_STATIC, 32'sh0001_8000, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd31, SEL_COULOMB, 32'sh0000_4000, 16'sd0, 1'b0));
    send_beat(mk_beat(ACT_LOAD, 5'd31, SEL_INV_VS, 32'shFFF6_0000, 16'sd0, 1'b0));
    // zero, inside the deadband, just outside on both sides, past the dip, extremes
    send_beat(mk_beat(ACT_PROC, 5'd0, SEL_INERTIA, 32'sh0, 16'sd0, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd0, SEL_INERTIA, 32'sh0, 16'sd1, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd0, SEL_INERTIA, 32'sh0, 16'sd2, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd0, SEL_INERTIA, 32'sh0, -16'sd2, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd0, SEL_INERTIA, 32'sh0, 16'sd20, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd0, SEL_INERTIA, 32'sh0, 16'sh7FFF, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd0, SEL_INERTIA, 32'sh0, 16'sh8000, 1'b1));
    // failed read keeps the stored state but still yields a command
    send_beat(mk_beat(ACT_PROC, 5'd0, SEL_INERTIA, 32'sh0, 16'sd100, 1'b0));
    send_beat(mk_beat(ACT_PROC, 5'd31, SEL_INERTIA, 32'sh0, 16'sd5, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd31, SEL_INERTIA, 32'sh0, 16'sh8000, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd31, SEL_INERTIA, 32'sh0, 16'sh7FFF, 1'b1));
    send_beat(mk_beat(ACT_PROC, 5'd31, SEL_INERTIA, 32'sh0, 16'sd3, 1'b0));

    ph_limit[4] = $urandom_range(1, 32767);
    ph_mpt[4]   = $urandom_range(1, 32'h7FFF_FFFF);
    ph_rate[4]  = $urandom_range(1, 1000);
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_regs(LIMIT_W'(ph_limit[p]), MPT_W'(ph_mpt[p]), RATE_W'(ph_rate[p]));
      recv_quiet = (p == 2 || p == 4);
      send_quiet = (p == 3 || p == 4);
      // sender keeps streaming back to back while the sink sits on a result
      if (p == 3) hold_req = 1'b1;
      done = 0;
      while (done < PHASE_BEATS) begin
        make_random_beat(b);
        send_beat(b);
        if (!(b.action == ACT_LOAD && b.sel >= COEFS)) done++;
      end
    end

    drain_results();
    $display("Covered %0d loads (%0d with a stray selector) and %0d joint samples (%0d failed reads)",
             n_loads, n_stray, n_samples, n_bad_read);
    $display("Checked %0d goal-current beats over %0d register settings, %0d long sink hold-offs",
             sb.checked, NUM_PHASES + 1, holds_done);
    if (sb.mismatches == 0) begin
      $display("stribeck_friction_feedforward_test: PASS");
    end else begin
      $display("stribeck_friction_feedforward_test: FAIL");
    end
    $finish;
  end

endmodule
